// ===== rtl/nirpd_pkg.sv =====
// Shared types, register indexes and constants of the NEC IR pulse decoder.
`timescale 1ns / 1ps

package nirpd_pkg;

    localparam int LEN_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int FRAME_BITS  = 32;
    localparam int COUNT_W     = 6;
    localparam int CMD_W       = 8;
    localparam int CNT_W       = 16;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0] START_LENGTH_RST   = 16'd336;
    localparam logic [LEN_W-1:0] REPEAT_LENGTH_RST  = 16'd280;
    localparam logic [LEN_W-1:0] ONE_LENGTH_RST     = 16'd56;
    localparam logic [LEN_W-1:0] ZERO_LENGTH_RST    = 16'd28;
    localparam logic [LEN_W-1:0] BIT_TOLERANCE_RST  = 16'd13;
    localparam logic [LEN_W-1:0] LONG_TOLERANCE_RST = 16'd27;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_LENGTH   = 3'd0,
        REG_REPEAT_LENGTH  = 3'd1,
        REG_ONE_LENGTH     = 3'd2,
        REG_ZERO_LENGTH    = 3'd3,
        REG_BIT_TOLERANCE  = 3'd4,
        REG_LONG_TOLERANCE = 3'd5
    } reg_index_t;

    // Pulse class, decided by the front end
    typedef enum logic [2:0] {
        CLS_START  = 3'd0,
        CLS_REPEAT = 3'd1,
        CLS_ONE    = 3'd2,
        CLS_ZERO   = 3'd3,
        CLS_BAD    = 3'd4
    } pulse_class_t;

    // Head of the class queue as seen by the back end
    typedef struct packed {
        logic         valid;
        pulse_class_t cls;
    } cls_req_t;

    // One result request
    typedef struct packed {
        logic             new_command;
        logic             repeat_seen;
        logic [CMD_W-1:0] command_code;
        logic [CNT_W-1:0] repeat_count;
        logic [CNT_W-1:0] error_count;
    } result_t;

endpackage

// ===== rtl/nirpd_front.sv =====
// Front end: configuration registers, window classification and class queue.
`timescale 1ns / 1ps

module nirpd_front
    import nirpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]       cfg_data,
    input  logic                   push,
    input  logic [LEN_W-1:0]       interval_length,
    output logic                   full,
    output cls_req_t               cls_req,
    input  logic                   cls_pop
);

    logic [LEN_W-1:0] start_length_reg;
    logic [LEN_W-1:0] repeat_length_reg;
    logic [LEN_W-1:0] one_length_reg;
    logic [LEN_W-1:0] zero_length_reg;
    logic [LEN_W-1:0] bit_tolerance_reg;
    logic [LEN_W-1:0] long_tolerance_reg;

    pulse_class_t q_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    pulse_class_t cls_now;
    logic         do_push;
    logic         do_pop;

    // True when c - t <= v <= c + t, computed without wrap
    function automatic logic in_window(input logic [LEN_W-1:0] v,
                                       input logic [LEN_W-1:0] c,
                                       input logic [LEN_W-1:0] t);
        logic [LEN_W:0] vt;
        logic [LEN_W:0] ct;
        begin
            vt = {1'b0, v} + {1'b0, t};
            ct = {1'b0, c} + {1'b0, t};
            in_window = (vt >= {1'b0, c}) && ({1'b0, v} <= ct);
        end
    endfunction

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_length_reg   <= START_LENGTH_RST;
            repeat_length_reg  <= REPEAT_LENGTH_RST;
            one_length_reg     <= ONE_LENGTH_RST;
            zero_length_reg    <= ZERO_LENGTH_RST;
            bit_tolerance_reg  <= BIT_TOLERANCE_RST;
            long_tolerance_reg <= LONG_TOLERANCE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_LENGTH:   start_length_reg   <= cfg_data;
                REG_REPEAT_LENGTH:  repeat_length_reg  <= cfg_data;
                REG_ONE_LENGTH:     one_length_reg     <= cfg_data;
                REG_ZERO_LENGTH:    zero_length_reg    <= cfg_data;
                REG_BIT_TOLERANCE:  bit_tolerance_reg  <= cfg_data;
                REG_LONG_TOLERANCE: long_tolerance_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Classify the interval; earlier windows win on overlap
    always_comb
    begin
        if (in_window(interval_length, start_length_reg, long_tolerance_reg))
            cls_now = CLS_START;
        else if (in_window(interval_length, repeat_length_reg, long_tolerance_reg))
            cls_now = CLS_REPEAT;
        else if (in_window(interval_length, one_length_reg, bit_tolerance_reg))
            cls_now = CLS_ONE;
        else if (in_window(interval_length, zero_length_reg, bit_tolerance_reg))
            cls_now = CLS_ZERO;
        else
            cls_now = CLS_BAD;
    end

    // Queue handshake
    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = cls_pop && (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    // Advance queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Store the class
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= cls_now;
    end

    assign cls_req.valid = (count_reg != 2'd0);
    assign cls_req.cls   = q_reg[rd_ptr_reg];

endmodule

// ===== rtl/nirpd_back.sv =====
// Back end: frame decode state and the result queue.
`timescale 1ns / 1ps

module nirpd_back
    import nirpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cls_req_t cls_req,
    output logic     cls_pop,
    output result_t  res_head,
    output logic     empty,
    input  logic     pop
);

    logic                  armed_reg;
    logic                  armed_next;
    logic [COUNT_W-1:0]    bit_count_reg;
    logic [COUNT_W-1:0]    bit_count_next;
    logic [FRAME_BITS-1:0] shift_bits_reg;
    logic [FRAME_BITS-1:0] shift_bits_next;
    logic [CMD_W-1:0]      held_command_reg;
    logic [CMD_W-1:0]      held_command_next;
    logic [CNT_W-1:0]      repeats_reg;
    logic [CNT_W-1:0]      repeats_next;
    logic [CNT_W-1:0]      bad_pulses_reg;
    logic [CNT_W-1:0]      bad_pulses_next;
    logic                  fresh;
    logic                  rep;
    result_t               res_now;

    result_t               rq_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  do_pop;

    // Take a class whenever the result queue has room
    assign cls_pop = cls_req.valid && (count_reg != 2'd2);

    // Decode one pulse
    always_comb
    begin
        armed_next        = armed_reg;
        bit_count_next    = bit_count_reg;
        shift_bits_next   = shift_bits_reg;
        held_command_next = held_command_reg;
        repeats_next      = repeats_reg;
        bad_pulses_next   = bad_pulses_reg;
        fresh             = 1'b0;
        rep               = 1'b0;
        if (!armed_reg)
        begin
            armed_next     = 1'b1;
            bit_count_next = '0;
        end
        else
        begin
            case (cls_req.cls)
                CLS_START:
                begin
                    bit_count_next  = '0;
                    shift_bits_next = '0;
                end
                CLS_REPEAT:
                begin
                    rep          = 1'b1;
                    repeats_next = repeats_reg + CNT_W'(1);
                end
                default:
                begin
                    repeats_next = '0;
                    if (bit_count_reg < COUNT_W'(FRAME_BITS))
                    begin
                        shift_bits_next = {shift_bits_reg[FRAME_BITS-2:0],
                                           (cls_req.cls == CLS_ONE)};
                        if (cls_req.cls == CLS_BAD)
                            bad_pulses_next = bad_pulses_reg + CNT_W'(1);
                        bit_count_next = bit_count_reg + COUNT_W'(1);
                        // Frame complete: check command against its complement
                        if (bit_count_next == COUNT_W'(FRAME_BITS))
                        begin
                            if (shift_bits_next[15:8] == ~shift_bits_next[7:0])
                            begin
                                held_command_next = shift_bits_next[15:8];
                                fresh             = 1'b1;
                            end
                            armed_next = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    // Update decode state on each taken class
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b0;
            bit_count_reg    <= '0;
            shift_bits_reg   <= '0;
            held_command_reg <= '0;
            repeats_reg      <= '0;
            bad_pulses_reg   <= '0;
        end
        else if (cls_pop)
        begin
            armed_reg        <= armed_next;
            bit_count_reg    <= bit_count_next;
            shift_bits_reg   <= shift_bits_next;
            held_command_reg <= held_command_next;
            repeats_reg      <= repeats_next;
            bad_pulses_reg   <= bad_pulses_next;
        end
    end

    assign res_now.new_command  = fresh;
    assign res_now.repeat_seen  = rep;
    assign res_now.command_code = held_command_next;
    assign res_now.repeat_count = repeats_next;
    assign res_now.error_count  = bad_pulses_next;

    // Result queue handshake
    assign empty  = (count_reg == 2'd0);
    assign do_pop = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (cls_pop && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !cls_pop)
            count_next = count_reg - 2'd1;
    end

    // Advance result queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (cls_pop)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Store the result request
    always_ff @(posedge clk)
    begin
        if (cls_pop)
            rq_reg[wr_ptr_reg] <= res_now;
    end

    assign res_head = rq_reg[rd_ptr_reg];

endmodule

// ===== rtl/nec_ir_pulse_decoder.sv =====
// NEC IR pulse decoder: interval classification front end and frame decode back end.
// A pushed request is registered in the class queue, then in the result queue, and
// then shows on the result ports. Throughput: one request per cycle while full is
// low; each side has a 2-entry queue that decouples it.
// Reset: rst_n asynchronous, active low; clears queues, decode state and counters,
// and loads the default window lengths and tolerances.
`timescale 1ns / 1ps

module nec_ir_pulse_decoder
    import nirpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]       cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [LEN_W-1:0]       interval_length,
    output logic                   empty,
    input  logic                   pop,
    output logic                   new_command,
    output logic                   repeat_seen,
    output logic [CMD_W-1:0]       command_code,
    output logic [CNT_W-1:0]       repeat_count,
    output logic [CNT_W-1:0]       error_count
);

    cls_req_t cls_req;
    logic     cls_pop;
    result_t  res_head;

    nirpd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .interval_length (interval_length),
        .full            (full),
        .cls_req         (cls_req),
        .cls_pop         (cls_pop)
    );

    nirpd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cls_req  (cls_req),
        .cls_pop  (cls_pop),
        .res_head (res_head),
        .empty    (empty),
        .pop      (pop)
    );

    assign new_command  = res_head.new_command;
    assign repeat_seen  = res_head.repeat_seen;
    assign command_code = res_head.command_code;
    assign repeat_count = res_head.repeat_count;
    assign error_count  = res_head.error_count;

    // A pulse is never both a repeat and a frame end
    a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(new_command && repeat_seen))
        else $error("new_command and repeat_seen both set");

    // Full front queue means the back end has a pending class
    a_full_pending: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> cls_req.valid)
        else $error("front full without pending class");

    // A request entering idle queues passes the class queue and reaches the result side
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !cls_req.valid && empty) |-> ##2 !empty)
        else $error("request did not reach result queue");

    // A completed frame ends on a bit pulse, which clears the repeat run
    a_cmd_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && new_command) |-> (repeat_count == '0))
        else $error("new command with nonzero repeat count");

endmodule
